[src/gds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg
// Shared widths, types and edge indexing for the 9-node graph signature.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int NodeCount    = 9;
  localparam int EdgeBits     = NodeCount * (NodeCount - 1) / 2;
  localparam int EdgeIdxW     = $clog2(EdgeBits);
  localparam int DegW         = 4;
  localparam int PairsPerNode = (NodeCount - 1) * (NodeCount - 2) / 2;
  localparam int PairIdxW     = $clog2(PairsPerNode);
  localparam int TriW         = $clog2(PairsPerNode + 1);
  localparam int TriWordW     = DegW * NodeCount + 1;

  typedef logic [NodeCount-1:0][DegW-1:0] deg_vec_t;
  typedef logic [NodeCount-1:0][TriW-1:0] tri_cnt_t;

  // Bit position of the edge between two distinct nodes, in either order.
  function automatic logic [EdgeIdxW-1:0] edge_idx(input int a, input int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return EdgeIdxW'(((hi * (hi - 1)) >> 1) + lo);
  endfunction

endpackage

[src/gds_degree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_degree
// Per-node degree count from the edge mask.
// ----------------------------------------------------------------------------
module gds_degree (
  input  logic [gds_pkg::EdgeBits-1:0] mask,
  output gds_pkg::deg_vec_t            deg
);

  always_comb begin
    logic [gds_pkg::NodeCount-1:0] nbr;
    deg = '0;
    for (int i = 0; i < gds_pkg::NodeCount; i++) begin
      nbr = '0;
      for (int j = 0; j < gds_pkg::NodeCount; j++) begin
        if (j != i) begin
          nbr[j] = mask[gds_pkg::edge_idx(i, j)];
        end
      end
      deg[i] = gds_pkg::DegW'($countones(nbr));
    end
  end

endmodule

[src/gds_sort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_sort
// Descending sort of the node degrees by parallel rank and scatter.
// ----------------------------------------------------------------------------
module gds_sort (
  input  gds_pkg::deg_vec_t deg,
  output gds_pkg::deg_vec_t sorted
);

  always_comb begin
    logic [gds_pkg::NodeCount-1:0] ahead;
    logic [gds_pkg::DegW-1:0]      rank;
    sorted = '0;
    for (int i = 0; i < gds_pkg::NodeCount; i++) begin
      // break ties by node index so ranks form a permutation
      for (int j = 0; j < gds_pkg::NodeCount; j++) begin
        ahead[j] = (deg[j] > deg[i]) || ((deg[j] == deg[i]) && (j < i));
      end
      rank = gds_pkg::DegW'($countones(ahead));
      for (int p = 0; p < gds_pkg::NodeCount; p++) begin
        if (rank == gds_pkg::DegW'(p)) begin
          sorted[p] = sorted[p] | deg[i];
        end
      end
    end
  end

endmodule

[src/gds_tri.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_tri
// Per-node triangle membership count, folded into a nibble-weighted word.
// ----------------------------------------------------------------------------
module gds_tri (
  input  logic [gds_pkg::EdgeBits-1:0] mask,
  output logic [gds_pkg::TriWordW-1:0] word
);

  gds_pkg::tri_cnt_t cnt;

  always_comb begin
    logic [gds_pkg::PairsPerNode-1:0] hit;
    logic [gds_pkg::PairIdxW-1:0]     n;
    cnt = '0;
    for (int i = 0; i < gds_pkg::NodeCount; i++) begin
      hit = '0;
      n   = '0;
      for (int j = 0; j < gds_pkg::NodeCount; j++) begin
        for (int k = j + 1; k < gds_pkg::NodeCount; k++) begin
          if (j != i && k != i) begin
            hit[n] = mask[gds_pkg::edge_idx(i, j)] & mask[gds_pkg::edge_idx(i, k)] &
                     mask[gds_pkg::edge_idx(j, k)];
            n = n + 1'b1;
          end
        end
      end
      cnt[i] = gds_pkg::TriW'($countones(hit));
    end
  end

  // Low nibbles sit side by side; only the top count bit spills over.
  always_comb begin
    logic [gds_pkg::TriWordW-1:0] lo;
    logic [gds_pkg::TriWordW-1:0] hi;
    lo = '0;
    hi = '0;
    for (int i = 0; i < gds_pkg::NodeCount; i++) begin
      lo[gds_pkg::DegW*i +: gds_pkg::DegW] = cnt[i][gds_pkg::DegW-1:0];
      hi[gds_pkg::DegW*i + gds_pkg::DegW]  = cnt[i][gds_pkg::TriW-1];
    end
    word = lo + hi;
  end

endmodule

[src/graph_degree_triangle_signature.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_degree_triangle_signature
// Pipeline: an accepted edge mask is captured in the input register, then
//   the degree, sort and triangle logic feed the result register.
// Throughput: one edge mask per cycle, set by the single logic stage, while
//   the output is not stalled by sig_ready low with a signature waiting.
// Reset: rst clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module graph_degree_triangle_signature (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         edge_valid,
  output logic                         edge_ready,
  input  logic [gds_pkg::EdgeBits-1:0] edge_mask,
  output logic                         sig_valid,
  input  logic                         sig_ready,
  output logic [gds_pkg::EdgeBits-1:0] degree_vector,
  output logic [gds_pkg::EdgeBits-1:0] sorted_degrees,
  output logic [gds_pkg::TriWordW-1:0] triangle_word
);

  logic                         s1_valid;
  logic [gds_pkg::EdgeBits-1:0] s1_mask;
  logic                         s1_advance;
  gds_pkg::deg_vec_t            deg;
  gds_pkg::deg_vec_t            srt;
  logic [gds_pkg::TriWordW-1:0] tri_word;

  assign s1_advance = !sig_valid || sig_ready;
  assign edge_ready = !s1_valid || s1_advance;

  gds_degree u_degree (
    .mask (s1_mask),
    .deg  (deg)
  );

  gds_sort u_sort (
    .deg    (deg),
    .sorted (srt)
  );

  gds_tri u_tri (
    .mask (s1_mask),
    .word (tri_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      sig_valid <= 1'b0;
    end else begin
      if (edge_ready) begin
        s1_valid <= edge_valid;
      end
      if (s1_advance) begin
        sig_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (edge_ready && edge_valid) begin
      s1_mask <= edge_mask;
    end
    if (s1_advance && s1_valid) begin
      degree_vector  <= deg;
      sorted_degrees <= srt;
      triangle_word  <= tri_word;
    end
  end

  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    edge_valid && edge_ready |=> s1_valid)
    else $error("accepted edge mask not held in input stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_mask))
    else $error("input stage lost its item while blocked");

  a_sorted_top: assert property (@(posedge clk) disable iff (rst)
    sig_valid |-> sorted_degrees[gds_pkg::DegW-1:0] >= degree_vector[gds_pkg::DegW-1:0])
    else $error("largest sorted degree below node 0 degree");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    sig_valid && degree_vector == '0 |-> sorted_degrees == '0 && triangle_word == '0)
    else $error("empty graph gave nonzero signature");

endmodule
